// ===== sv/luc_pkg.sv =====
// Package: types, register indexes and constants of the lid usage controller.
package luc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned EchoW  = 15;
  localparam int unsigned UsesW  = 4;
  localparam int unsigned LevelW = 16;
  localparam int unsigned CfgW   = 32;

  localparam logic [EchoW-1:0] EchoTimeoutUs = EchoW'(20000);

  typedef enum logic [2:0] {
    REG_MAX_USES       = 3'd0,
    REG_MIN_ECHO_US    = 3'd1,
    REG_MAX_ECHO_US    = 3'd2,
    REG_HOLD_RESET_US  = 3'd3,
    REG_CLOSE_DELAY_US = 3'd4,
    REG_BEEP_US        = 3'd5,
    REG_OPEN_LEVEL     = 3'd6,
    REG_CLOSED_LEVEL   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [UsesW-1:0]  max_uses;
    logic [EchoW-1:0]  min_echo_us;
    logic [EchoW-1:0]  max_echo_us;
    logic [TimeW-1:0]  hold_reset_us;
    logic [TimeW-1:0]  close_delay_us;
    logic [TimeW-1:0]  beep_us;
    logic [LevelW-1:0] open_level;
    logic [LevelW-1:0] closed_level;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    max_uses:       UsesW'(4),
    min_echo_us:    EchoW'(59),
    max_echo_us:    EchoW'(874),
    hold_reset_us:  TimeW'(5000000),
    close_delay_us: TimeW'(3000000),
    beep_us:        TimeW'(2000000),
    open_level:     LevelW'(2400),
    closed_level:   LevelW'(500)
  };

  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic             button_pressed;
    logic             echo_valid;
    logic [EchoW-1:0] echo_width_us;
  } item_t;

  typedef struct packed {
    logic [LevelW-1:0] servo_level;
    logic              green_led;
    logic              red_led;
    logic              yellow_led;
    logic              orange_led;
    logic              buzzer;
    logic              reset_chirp;
    logic [UsesW-1:0]  uses;
  } result_t;

  typedef struct packed {
    logic [UsesW-1:0] use_count;
    logic             lid_open;
    logic             beeping;
    logic             reset_latched;
    logic             hold_active;
    logic [TimeW-1:0] hold_start;
    logic [TimeW-1:0] open_time;
    logic [TimeW-1:0] beep_start;
    logic             servo_is_open;
    logic             led_yellow_state;
    logic             led_orange_state;
    logic             buzzer_state;
  } state_t;

endpackage

// ===== sv/luc_if.sv =====
// Interfaces: valid/ready channels for poll ticks and results.
interface luc_item_if;
  import luc_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_us;
  logic             button_pressed;
  logic             echo_valid;
  logic [EchoW-1:0] echo_width_us;

  modport source (output valid, now_us, button_pressed, echo_valid, echo_width_us,
                  input ready);
  modport sink   (input valid, now_us, button_pressed, echo_valid, echo_width_us,
                  output ready);
endinterface

interface luc_result_if;
  import luc_pkg::*;

  logic              valid;
  logic              ready;
  logic [LevelW-1:0] servo_level;
  logic              green_led;
  logic              red_led;
  logic              yellow_led;
  logic              orange_led;
  logic              buzzer;
  logic              reset_chirp;
  logic [UsesW-1:0]  uses;

  modport source (output valid, servo_level, green_led, red_led, yellow_led,
                  orange_led, buzzer, reset_chirp, uses, input ready);
  modport sink   (input valid, servo_level, green_led, red_led, yellow_led,
                  orange_led, buzzer, reset_chirp, uses, output ready);
endinterface

// ===== sv/luc_step.sv =====
// Next-state and result logic for one poll tick.
module luc_step (
  input  luc_pkg::cfg_t    cfg,
  input  luc_pkg::state_t  st,
  input  luc_pkg::item_t   item,
  output luc_pkg::state_t  st_next,
  output luc_pkg::result_t res
);
  import luc_pkg::*;

  logic             present;
  logic             btn;
  logic [TimeW-1:0] hold_el;
  logic [TimeW-1:0] open_el;
  logic [TimeW-1:0] beep_el;
  logic             hold_exp;
  logic             close_exp;
  logic             beep_exp;
  logic             chirp;
  logic             started;
  logic             green;

  assign btn     = item.button_pressed;
  assign present = item.echo_valid && (item.echo_width_us <= EchoTimeoutUs) &&
                   (item.echo_width_us >= cfg.min_echo_us) &&
                   (item.echo_width_us <= cfg.max_echo_us);

  assign hold_el   = item.now_us - st.hold_start;
  assign open_el   = item.now_us - st.open_time;
  assign beep_el   = item.now_us - st.beep_start;
  assign hold_exp  = st.hold_active && (hold_el > cfg.hold_reset_us);
  assign close_exp = open_el > cfg.close_delay_us;
  assign beep_exp  = beep_el > cfg.beep_us;

  always_comb begin
    st_next = st;
    chirp   = 1'b0;
    started = 1'b0;

    if (btn) begin
      if (!st.hold_active) begin
        st_next.hold_start  = item.now_us;
        st_next.hold_active = 1'b1;
      end
      if (hold_exp && !st.reset_latched) begin
        st_next.use_count     = '0;
        st_next.buzzer_state  = 1'b0;
        st_next.servo_is_open = 1'b0;
        st_next.reset_latched = 1'b1;
        chirp                 = 1'b1;
      end
    end else begin
      st_next.hold_start    = '0;
      st_next.hold_active   = 1'b0;
      st_next.reset_latched = 1'b0;
    end

    if (st_next.use_count < cfg.max_uses) begin
      if (present || (btn && !st_next.reset_latched)) begin
        st_next.servo_is_open = 1'b1;
        st_next.open_time     = item.now_us;
        if (present) st_next.led_yellow_state = 1'b1;
        if (btn) st_next.led_orange_state = 1'b1;
        if (!st.lid_open) begin
          st_next.buzzer_state = 1'b1;
          st_next.beep_start   = item.now_us;
          st_next.beeping      = 1'b1;
          st_next.use_count    = st_next.use_count + UsesW'(1);
          st_next.lid_open     = 1'b1;
          started              = 1'b1;
        end
      end
      if (!present && !btn && st.lid_open && close_exp) begin
        st_next.servo_is_open    = 1'b0;
        st_next.led_yellow_state = 1'b0;
        st_next.led_orange_state = 1'b0;
        st_next.lid_open         = 1'b0;
      end
    end else begin
      st_next.led_yellow_state = 1'b0;
      st_next.led_orange_state = 1'b0;
      st_next.servo_is_open    = 1'b0;
    end

    if (st_next.beeping && !started && beep_exp) begin
      st_next.buzzer_state = 1'b0;
      st_next.beeping      = 1'b0;
    end
  end

  assign green = st_next.use_count < cfg.max_uses;

  always_comb begin
    res.servo_level = st_next.servo_is_open ? cfg.open_level : cfg.closed_level;
    res.green_led   = green;
    res.red_led     = !green;
    res.yellow_led  = st_next.led_yellow_state;
    res.orange_led  = st_next.led_orange_state;
    res.buzzer      = st_next.buzzer_state;
    res.reset_chirp = chirp;
    res.uses        = st_next.use_count;
  end

endmodule

// ===== sv/lid_usage_controller.sv =====
// Top level: lid usage controller with config registers, tick and result registers.
//
// Each poll tick is one transaction on item_in; it yields exactly one transaction on
// result_out. A tick enters an input register; its state update and result are
// computed from that register and land in the result register, where the result is
// offered to result_out. One tick is accepted every cycle while results are taken;
// the combinational update of the lid state is what carries that rate, and a stalled
// result holds the stage behind it.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge and
// belong to idle periods.
module lid_usage_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  luc_pkg::cfg_idx_t          cfg_index,
  input  logic [luc_pkg::CfgW-1:0]   cfg_data,
  luc_item_if.sink                   item_in,
  luc_result_if.source               result_out
);
  import luc_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item_q;
  logic    item_valid;
  result_t res_next;
  result_t res_q;
  logic    res_valid;
  logic    advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_USES:       cfg.max_uses       <= cfg_data[UsesW-1:0];
        REG_MIN_ECHO_US:    cfg.min_echo_us    <= cfg_data[EchoW-1:0];
        REG_MAX_ECHO_US:    cfg.max_echo_us    <= cfg_data[EchoW-1:0];
        REG_HOLD_RESET_US:  cfg.hold_reset_us  <= cfg_data[TimeW-1:0];
        REG_CLOSE_DELAY_US: cfg.close_delay_us <= cfg_data[TimeW-1:0];
        REG_BEEP_US:        cfg.beep_us        <= cfg_data[TimeW-1:0];
        REG_OPEN_LEVEL:     cfg.open_level     <= cfg_data[LevelW-1:0];
        REG_CLOSED_LEVEL:   cfg.closed_level   <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = item_valid && (!res_valid || result_out.ready);
  assign item_in.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_in.ready) begin
      item_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      item_q.now_us         <= item_in.now_us;
      item_q.button_pressed <= item_in.button_pressed;
      item_q.echo_valid     <= item_in.echo_valid;
      item_q.echo_width_us  <= item_in.echo_width_us;
    end
  end

  luc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item_q),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result_out.valid       = res_valid;
  assign result_out.servo_level = res_q.servo_level;
  assign result_out.green_led   = res_q.green_led;
  assign result_out.red_led     = res_q.red_led;
  assign result_out.yellow_led  = res_q.yellow_led;
  assign result_out.orange_led  = res_q.orange_led;
  assign result_out.buzzer      = res_q.buzzer;
  assign result_out.reset_chirp = res_q.reset_chirp;
  assign result_out.uses        = res_q.uses;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> item_in.ready)
    else $error("tick refused while result register empty");

  a_led_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_q.green_led != res_q.red_led))
    else $error("green and red indicators not complementary");

  a_buzzer_needs_beep: assert property (@(posedge clk) disable iff (rst)
    st.buzzer_state |-> st.beeping)
    else $error("buzzer on without a running beep");

  a_result_in_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result_out.ready |=> res_valid && $stable(res_q))
    else $error("pending result dropped or changed");

endmodule
